@@ sv/kbl_pkg.sv @@
// Shared types, codes and defaults for the keyed balance ledger.
package kbl_pkg;

	localparam int DEF_MAX_ENTRIES   = 64;
	localparam int DEF_ADDRESS_BYTES = 20;
	localparam int AMT_W             = 64;

	localparam logic [2:0] CMD_DEPOSIT = 3'd0;
	localparam logic [2:0] CMD_BIND    = 3'd1;
	localparam logic [2:0] CMD_UNBIND  = 3'd2;
	localparam logic [2:0] CMD_PAY     = 3'd3;
	localparam logic [2:0] CMD_GET     = 3'd4;
	localparam logic [2:0] CMD_RELEASE = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_SHORT = 2'd2;

	typedef struct packed {
		logic [2:0]       cmd;
		logic [63:0]      owner_word0;
		logic [63:0]      owner_word1;
		logic [31:0]      owner_word2;
		logic [AMT_W-1:0] amount;
	} kbl_in_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [AMT_W-1:0] free_amount;
		logic [AMT_W-1:0] locked_amount;
	} kbl_out_t;

	typedef struct packed {
		logic [AMT_W-1:0] free_bal;
		logic [AMT_W-1:0] locked_bal;
	} kbl_bal_t;

	// controls for the shared adder
	typedef struct packed {
		logic             sub;
		logic [AMT_W-1:0] a;
		logic [AMT_W-1:0] b;
	} kbl_alu_req_t;

	typedef struct packed {
		logic [AMT_W-1:0] sum;
		logic             borrow;
	} kbl_alu_rsp_t;

endpackage

@@ sv/kbl_alu.sv @@
// Shared 64-bit add/subtract unit with borrow-out for shortfall detection.
module kbl_alu (
	input  kbl_pkg::kbl_alu_req_t req,
	output kbl_pkg::kbl_alu_rsp_t rsp
);
	import kbl_pkg::*;

	logic [AMT_W:0] wide;

	always_comb begin
		if (req.sub) begin
			wide = {1'b0, req.a} - {1'b0, req.b};
		end else begin
			wide = {1'b0, req.a} + {1'b0, req.b};
		end
		rsp.sum    = wide[AMT_W-1:0];
		rsp.borrow = req.sub & wide[AMT_W];
	end

endmodule

@@ sv/kbl_key_store.sv @@
// Owner key memory with registered read and match compare.
module kbl_key_store #(
	parameter int DEPTH = kbl_pkg::DEF_MAX_ENTRIES,
	parameter int KEY_W = 8 * kbl_pkg::DEF_ADDRESS_BYTES,
	parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IW-1:0]    waddr,
	input  logic [KEY_W-1:0] wdata,
	input  logic [IW-1:0]    raddr,
	input  logic [KEY_W-1:0] key,
	output logic             hit
);
	logic [KEY_W-1:0] mem [DEPTH];
	logic [KEY_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign hit = (rdata_q == key);

endmodule

@@ sv/kbl_bal_store.sv @@
// Free/locked balance memory, one entry per account, registered read.
module kbl_bal_store #(
	parameter int DEPTH = kbl_pkg::DEF_MAX_ENTRIES,
	parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [IW-1:0]     addr,
	input  kbl_pkg::kbl_bal_t wdata,
	output kbl_pkg::kbl_bal_t rdata
);
	import kbl_pkg::*;

	kbl_bal_t mem [DEPTH];
	kbl_bal_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

@@ sv/keyed_balance_ledger.sv @@
// Keyed balance ledger top level: sequencer, search and update control.
// One command at a time. After start is taken the block scans the owner
// keys one entry per cycle from a key memory with one write and one read
// port, then reads the balances, runs one or two passes through the shared
// 64-bit adder and writes back. A bind or unbind takes the second adder
// pass unless the first pass finds a shortfall. A new owner is appended
// after a scan of all used entries; one refused by a full table ends with
// done after the scan, without a balance read or write. busy is high from
// acceptance until the cycle done is shown; done lasts one cycle and the
// receiver cannot stall it, so result must be captured in that cycle.
// There is no clearing pass.
module keyed_balance_ledger #(
	parameter int MAX_ENTRIES   = kbl_pkg::DEF_MAX_ENTRIES,
	parameter int ADDRESS_BYTES = kbl_pkg::DEF_ADDRESS_BYTES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  kbl_pkg::kbl_in_t  request,
	output logic              done,
	output kbl_pkg::kbl_out_t result
);
	import kbl_pkg::*;

	localparam int KEY_W = 8 * ADDRESS_BYTES;
	localparam int IW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW    = $clog2(MAX_ENTRIES + 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SEARCH = 3'd1;
	localparam logic [2:0] S_BAL_RD = 3'd2;
	localparam logic [2:0] S_LOAD   = 3'd3;
	localparam logic [2:0] S_OP1    = 3'd4;
	localparam logic [2:0] S_OP2    = 3'd5;
	localparam logic [2:0] S_WB     = 3'd6;

	logic [2:0]       state_q;
	logic [CW-1:0]    used_q;
	logic [CW-1:0]    scan_q;
	logic             pend_q;
	logic [IW-1:0]    pend_idx_q;
	logic [IW-1:0]    idx_q;
	logic             new_q;
	logic [2:0]       cmd_q;
	logic [AMT_W-1:0] amt_q;
	logic [KEY_W-1:0] key_q;
	logic [AMT_W-1:0] fr_q;
	logic [AMT_W-1:0] lk_q;
	logic [1:0]       status_q;
	logic             done_q;
	kbl_out_t         res_q;

	logic [159:0]     owner_full;
	logic             scan_more;
	logic             key_hit;
	logic             key_we;
	kbl_bal_t         bal_rd;
	kbl_bal_t         bal_wr;
	logic             bal_we;
	kbl_alu_req_t     alu_req;
	kbl_alu_rsp_t     alu_rsp;
	logic             uses_locked;
	logic             is_sub;
	logic             is_add;
	logic             two_step;

	assign owner_full = {request.owner_word2, request.owner_word1, request.owner_word0};
	assign scan_more  = (scan_q < used_q);

	assign uses_locked = (cmd_q == CMD_UNBIND) || (cmd_q == CMD_PAY);
	assign is_sub      = (cmd_q == CMD_BIND) || (cmd_q == CMD_UNBIND) ||
	                     (cmd_q == CMD_PAY) || (cmd_q == CMD_RELEASE);
	assign is_add      = (cmd_q == CMD_DEPOSIT);
	assign two_step    = (cmd_q == CMD_BIND) || (cmd_q == CMD_UNBIND);

	// new owner is appended when the scan ends without a hit and the table has room
	assign key_we = (state_q == S_SEARCH) && !(pend_q && key_hit) && !pend_q &&
	                !scan_more && (used_q != CW'(MAX_ENTRIES));

	kbl_key_store #(
		.DEPTH (MAX_ENTRIES),
		.KEY_W (KEY_W),
		.IW    (IW)
	) u_keys (
		.clk   (clk),
		.we    (key_we),
		.waddr (used_q[IW-1:0]),
		.wdata (key_q),
		.raddr (scan_q[IW-1:0]),
		.key   (key_q),
		.hit   (key_hit)
	);

	assign bal_we          = (state_q == S_WB);
	assign bal_wr.free_bal   = fr_q;
	assign bal_wr.locked_bal = lk_q;

	kbl_bal_store #(
		.DEPTH (MAX_ENTRIES),
		.IW    (IW)
	) u_bal (
		.clk   (clk),
		.we    (bal_we),
		.addr  (idx_q),
		.wdata (bal_wr),
		.rdata (bal_rd)
	);

	always_comb begin
		alu_req.b = amt_q;
		if (state_q == S_OP2) begin
			alu_req.sub = 1'b0;
			alu_req.a   = (cmd_q == CMD_BIND) ? lk_q : fr_q;
		end else begin
			alu_req.sub = is_sub;
			alu_req.a   = uses_locked ? lk_q : fr_q;
		end
	end

	kbl_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q  <= '0;
			scan_q  <= '0;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_SEARCH;
						scan_q  <= '0;
						pend_q  <= 1'b0;
					end
				end
				S_SEARCH: begin
					if (pend_q && key_hit) begin
						state_q <= S_BAL_RD;
					end else if (!pend_q && !scan_more) begin
						if (used_q == CW'(MAX_ENTRIES)) begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end else begin
							used_q  <= used_q + 1'b1;
							state_q <= S_BAL_RD;
						end
					end else begin
						pend_q <= scan_more;
						if (scan_more) begin
							scan_q <= scan_q + 1'b1;
						end
					end
				end
				S_BAL_RD: state_q <= S_LOAD;
				S_LOAD:   state_q <= S_OP1;
				S_OP1: begin
					if (is_sub && alu_rsp.borrow) begin
						state_q <= S_WB;
					end else if ((is_sub || is_add) && two_step) begin
						state_q <= S_OP2;
					end else begin
						state_q <= S_WB;
					end
				end
				S_OP2: state_q <= S_WB;
				S_WB: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd_q    <= request.cmd;
					amt_q    <= request.amount;
					key_q    <= owner_full[KEY_W-1:0];
					status_q <= ST_OK;
				end
			end
			S_SEARCH: begin
				pend_idx_q <= scan_q[IW-1:0];
				if (pend_q && key_hit) begin
					idx_q <= pend_idx_q;
					new_q <= 1'b0;
				end else if (!pend_q && !scan_more) begin
					idx_q <= used_q[IW-1:0];
					new_q <= 1'b1;
					if (used_q == CW'(MAX_ENTRIES)) begin
						res_q.status        <= ST_FULL;
						res_q.free_amount   <= '0;
						res_q.locked_amount <= '0;
					end
				end
			end
			S_BAL_RD: begin
			end
			S_LOAD: begin
				fr_q <= new_q ? '0 : bal_rd.free_bal;
				lk_q <= new_q ? '0 : bal_rd.locked_bal;
			end
			S_OP1: begin
				if (is_sub && alu_rsp.borrow) begin
					status_q <= ST_SHORT;
				end else if (is_sub || is_add) begin
					if (uses_locked) begin
						lk_q <= alu_rsp.sum;
					end else begin
						fr_q <= alu_rsp.sum;
					end
				end
			end
			S_OP2: begin
				if (cmd_q == CMD_BIND) begin
					lk_q <= alu_rsp.sum;
				end else begin
					fr_q <= alu_rsp.sum;
				end
			end
			S_WB: begin
				res_q.status        <= status_q;
				res_q.free_amount   <= fr_q;
				res_q.locked_amount <= lk_q;
			end
			default: begin
			end
		endcase
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(MAX_ENTRIES))
		else $error("entry count above table size");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == ST_FULL |-> result.free_amount == '0 &&
		result.locked_amount == '0)
		else $error("table-full result carries nonzero balances");

	a_short_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == ST_SHORT |-> is_sub)
		else $error("shortfall reported for a non-debiting command");

	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		key_we |=> used_q == $past(used_q) + 1'b1)
		else $error("append did not advance the entry count");

endmodule
